/* src/lru_page_frame_table_defines.svh */
// Assertion macros used by the back RTL file (lpft_back) of the frame table.
`ifndef LRU_PAGE_FRAME_TABLE_DEFINES_SVH
`define LRU_PAGE_FRAME_TABLE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LPFT_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define LPFT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* src/lpft_pkg.sv */
`default_nettype none

package lpft_pkg;

  // Table geometry
  localparam int FRAMES   = 16;
  localparam int AGE_BITS = 32;
  localparam int IDX_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W    = $clog2(FRAMES + 1);

  // Field widths
  localparam int REF_W    = 31;
  localparam int PSIZE_W  = 16;
  localparam int NFRM_W   = 5;
  localparam int FIDX_W   = 4;
  localparam int TOTAL_W  = 32;
  localparam int CIDX_W   = 8;

  // Page number queue between front and back (depth a power of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // Register reset values
  localparam logic [PSIZE_W-1:0] PAGE_SIZE_RST = 16'd4096;
  localparam logic [NFRM_W-1:0]  FRAMES_RST    = 5'd16;

  typedef logic [REF_W-1:0]    page_t;
  typedef logic [AGE_BITS-1:0] age_t;
  typedef logic [IDX_W-1:0]    idx_t;

  localparam age_t AGE_MAX = {AGE_BITS{1'b1}};

  // Configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    REG_PAGE_SIZE     = 8'd0,
    REG_FRAMES_IN_USE = 8'd1
  } cfg_reg_e;

  // Front sequencer
  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } f_state_e;

  // Back sequencer
  typedef enum logic [1:0] {
    B_IDLE,
    B_LOOKUP,
    B_SCAN,
    B_REFILL
  } b_state_e;

  // One result item
  typedef struct packed {
    logic               fault;
    page_t              page_number;
    logic [FIDX_W-1:0]  frame_index;
    logic [TOTAL_W-1:0] fault_total;
  } res_t;

endpackage

`default_nettype wire

/* src/lpft_front.sv */
`default_nettype none

// Front: takes a reference and divides it by the page size, one quotient bit per cycle.
module lpft_front import lpft_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire logic [REF_W-1:0]   mem_ref_i,
  output logic                    full_o,
  input  wire logic [PSIZE_W-1:0] page_size_i,
  input  wire logic               q_full_i,
  output logic                    q_push_o,
  output page_t                   q_data_o
);

  localparam logic [4:0] LAST_STEP = 5'(REF_W - 1);

  f_state_e            state_q, state_d;
  logic [REF_W-1:0]    quo_q, quo_d;
  logic [PSIZE_W-1:0]  rem_q, rem_d;
  logic [PSIZE_W-1:0]  div_q;
  logic [4:0]          cnt_q, cnt_d;
  logic                accept;
  logic [PSIZE_W:0]    rem_sh;
  logic                q_bit;

  assign accept = push_i && (state_q == F_IDLE);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE:  if (push_i) state_d = F_DIV;
      F_DIV:   if (cnt_q == LAST_STEP) state_d = F_PUSH;
      F_PUSH:  if (!q_full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  // Restoring divide step; a zero divisor yields all ones
  always_comb begin
    rem_sh = {rem_q, quo_q[REF_W-1]};
    q_bit  = (rem_sh >= {1'b0, div_q});
    rem_d  = q_bit ? PSIZE_W'(rem_sh - {1'b0, div_q}) : rem_sh[PSIZE_W-1:0];
    quo_d  = {quo_q[REF_W-2:0], q_bit};
    cnt_d  = cnt_q + 5'd1;
  end

  // Outputs
  always_comb begin
    full_o   = (state_q != F_IDLE);
    q_push_o = (state_q == F_PUSH) && !q_full_i;
    q_data_o = quo_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept) cnt_q <= '0;
      else if (state_q == F_DIV) cnt_q <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      quo_q <= mem_ref_i;
      rem_q <= '0;
      div_q <= page_size_i;
    end else if (state_q == F_DIV) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

endmodule

`default_nettype wire

/* src/lpft_queue.sv */
`default_nettype none

// Short queue of page numbers between front and back.
module lpft_queue import lpft_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire page_t data_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output page_t      data_o,
  output logic       empty_o
);

  page_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

`default_nettype wire

/* src/lpft_back.sv */
`default_nettype none
`include "lru_page_frame_table_defines.svh"

// Back: frame lookup, aging, victim scan and refill; holds one finished result.
module lpft_back import lpft_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [NFRM_W-1:0] frames_in_use_i,
  input  wire logic              q_empty_i,
  input  wire page_t             q_data_i,
  output logic                   q_pop_o,
  input  wire logic              res_pop_i,
  output logic                   res_valid_o,
  output res_t                   res_o
);

  b_state_e           state_q, state_d;
  page_t              pg_q;
  idx_t               cursor_q, cursor_d;
  idx_t               victim_q, victim_d;
  age_t               best_q, best_d;
  page_t              page_q  [FRAMES];
  logic [FRAMES-1:0]  valid_q;
  age_t               age_q   [FRAMES];
  logic [TOTAL_W-1:0] fault_count_q, fault_inc;
  logic               out_valid_q;
  res_t               res_q, res_d;
  logic               res_we, age_step, fill;

  logic [CNT_W-1:0]   n_eff;
  idx_t               last_idx;
  logic [FRAMES-1:0]  in_use, hit_vec;
  logic               hit_any;
  idx_t               hit_idx;
  age_t               cur_age;

  // Effective frame count, clamped to one through FRAMES
  always_comb begin
    if (frames_in_use_i == '0) n_eff = CNT_W'(1);
    else if (32'(frames_in_use_i) > 32'(FRAMES)) n_eff = CNT_W'(FRAMES);
    else n_eff = CNT_W'(frames_in_use_i);
    last_idx = IDX_W'(n_eff - CNT_W'(1));
  end

  // Parallel tag compare and lowest matching frame
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < FRAMES; i++) begin
      in_use[i]  = (CNT_W'(i) < n_eff);
      hit_vec[i] = in_use[i] && valid_q[i] && (page_q[i] == pg_q);
    end
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (hit_vec[i]) hit_idx = IDX_W'(i);
    end
    hit_any = |hit_vec;
  end

  assign cur_age   = age_q[cursor_q];
  assign fault_inc = (fault_count_q == '1) ? fault_count_q : fault_count_q + 1'b1;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE:   if (!q_empty_i && !out_valid_q) state_d = B_LOOKUP;
      B_LOOKUP: state_d = hit_any ? B_IDLE : B_SCAN;
      B_SCAN:   if (cursor_q == last_idx) state_d = B_REFILL;
      B_REFILL: state_d = B_IDLE;
      default:  state_d = B_IDLE;
    endcase
  end

  // Outputs and datapath controls
  always_comb begin
    q_pop_o  = 1'b0;
    res_we   = 1'b0;
    age_step = 1'b0;
    fill     = 1'b0;
    res_d    = res_q;
    cursor_d = cursor_q;
    victim_d = victim_q;
    best_d   = best_q;
    case (state_q)
      B_IDLE: begin
        q_pop_o = !q_empty_i && !out_valid_q;
      end
      B_LOOKUP: begin
        age_step = 1'b1;
        cursor_d = '0;
        victim_d = '0;
        best_d   = '0;
        if (hit_any) begin
          res_we = 1'b1;
          res_d  = '{fault: 1'b0, page_number: pg_q,
                     frame_index: FIDX_W'(hit_idx), fault_total: fault_count_q};
        end
      end
      B_SCAN: begin
        // Strictly greater keeps ties on the lowest index
        if (cur_age > best_q) begin
          best_d   = cur_age;
          victim_d = cursor_q;
        end
        cursor_d = cursor_q + 1'b1;
      end
      B_REFILL: begin
        fill   = 1'b1;
        res_we = 1'b1;
        res_d  = '{fault: 1'b1, page_number: pg_q,
                   frame_index: FIDX_W'(victim_q), fault_total: fault_inc};
      end
      default: ;
    endcase
  end

  // Control, valid marks, ages and fault count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= B_IDLE;
      out_valid_q   <= 1'b0;
      valid_q       <= '0;
      fault_count_q <= '0;
      for (int i = 0; i < FRAMES; i++) age_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (res_we) out_valid_q <= 1'b1;
      else if (res_pop_i && out_valid_q) out_valid_q <= 1'b0;
      if (age_step) begin
        for (int i = 0; i < FRAMES; i++) begin
          if (in_use[i]) begin
            if (hit_vec[i]) age_q[i] <= '0;
            else if (age_q[i] != AGE_MAX) age_q[i] <= age_q[i] + 1'b1;
          end
        end
      end
      if (fill) begin
        age_q[victim_q]   <= '0;
        valid_q[victim_q] <= 1'b1;
        fault_count_q     <= fault_inc;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o) pg_q <= q_data_i;
    if (fill) page_q[victim_q] <= pg_q;
    if (res_we) res_q <= res_d;
    cursor_q <= cursor_d;
    victim_q <= victim_d;
    best_q   <= best_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

  `LPFT_ASSERT_IMPL(a_no_overwrite, clk_i, rst_ni, res_we, !out_valid_q)
  `LPFT_ASSERT_IMPL(a_scan_in_range, clk_i, rst_ni, state_q == B_SCAN, CNT_W'(cursor_q) < n_eff)
  `LPFT_ASSERT_NEXT(a_refill_faults, clk_i, rst_ni, state_q == B_REFILL, out_valid_q && res_q.fault)

endmodule

`default_nettype wire

/* src/lru_page_frame_table.sv */
// Flow: an accepted reference is divided by the page size, queued and looked up; on a miss
//   it is scanned for a victim (one frame per cycle over the frames in use) and refilled.
// The front takes no new reference until the page size divider has finished and pushed the last one.
// A finished result waits in an output register while the next reference is divided.
// Reset (rst_ni low, asynchronous): all frames empty, ages and fault count zero,
//   page_size 4096, frames_in_use 16; no clearing pass.
`default_nettype none

module lru_page_frame_table import lpft_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Reference queue side
  input  wire logic               push,
  output logic                    full,
  input  wire logic [REF_W-1:0]   mem_ref_i,
  // Result queue side
  output logic                    empty,
  input  wire logic               pop,
  output logic                    fault_o,
  output logic [REF_W-1:0]        page_number_o,
  output logic [FIDX_W-1:0]       frame_index_o,
  output logic [TOTAL_W-1:0]      fault_total_o,
  // Configuration writes
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CIDX_W-1:0]  cfg_index_i,
  input  wire logic [PSIZE_W-1:0] cfg_data_i
);

  logic [PSIZE_W-1:0] page_size_q;
  logic [NFRM_W-1:0]  frames_q;
  logic               q_push, q_full, q_pop, q_empty;
  page_t              q_wdata, q_rdata;
  logic               res_valid;
  res_t               res;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_size_q <= PAGE_SIZE_RST;
      frames_q    <= FRAMES_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_PAGE_SIZE:     page_size_q <= cfg_data_i;
        REG_FRAMES_IN_USE: frames_q    <= cfg_data_i[NFRM_W-1:0];
        default: ;
      endcase
    end
  end

  lpft_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .mem_ref_i   (mem_ref_i),
    .full_o      (full),
    .page_size_i (page_size_q),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  lpft_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  lpft_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .frames_in_use_i (frames_q),
    .q_empty_i       (q_empty),
    .q_data_i        (q_rdata),
    .q_pop_o         (q_pop),
    .res_pop_i       (pop),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  // Result ports
  assign empty         = !res_valid;
  assign fault_o       = res.fault;
  assign page_number_o = res.page_number;
  assign frame_index_o = res.frame_index;
  assign fault_total_o = res.fault_total;

endmodule

`default_nettype wire
